[hdl/rcfb_pkg.sv]
package rcfb_pkg;

   localparam int FrameBytes   = 13;
   localparam int CrcSpan      = 11;
   localparam int PayloadBytes = 7;
   localparam int BlockBytes   = 4;
   localparam int CntWidth     = $clog2(FrameBytes);

   localparam logic [7:0]  FrameHeader   = 8'h3E;
   localparam logic [7:0]  BroadcastAddr = 8'hCD;
   localparam logic [7:0]  LenField      = 8'h08;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPoly       = 16'hA001;

   typedef logic [7:0] byte_type;
   typedef byte_type [BlockBytes-1:0] block_type;
   typedef logic [255:0][15:0] crc_table_type;

   // Frame bytes up to the end of the payload, with the CRC run so far.
   typedef struct packed {
      byte_type [CrcSpan-1:0] body;
      logic [15:0]            crc;
   } frame_type;

   function automatic crc_table_type build_crc_table();
      crc_table_type tbl;
      logic [15:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 16'(i);
         for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
               c = (c >> 1) ^ CrcPoly;
            end else begin
               c = c >> 1;
            end
         end
         tbl[i] = c;
      end
      return tbl;
   endfunction

   localparam crc_table_type CrcTable = build_crc_table();

   // One byte of the reflected CRC, table driven.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_type data);
      return {8'h00, crc[15:8]} ^ CrcTable[crc[7:0] ^ data];
   endfunction

endpackage

[hdl/rcfb_if.sv]
interface rcfb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] motor_address;
   logic       broadcast;
   logic [7:0] command;
   logic [55:0] payload;

   modport source (output valid, output motor_address, output broadcast, output command,
                   output payload, input ready);
   modport sink (input valid, input motor_address, input broadcast, input command,
                 input payload, output ready);
endinterface

interface rcfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       frame_end;

   modport source (output valid, output tx_byte, output frame_end, input ready);
   modport sink (input valid, input tx_byte, input frame_end, output ready);
endinterface

[hdl/rs485_command_frame_builder.sv]
// Turns each motor command into a 13-byte bus frame: header 0x3E, address (0xCD when
// broadcast is set or the command equals the programmed set-address opcode), length 0x08,
// command, seven payload bytes and the CRC-16/Modbus over the first eleven bytes, low byte
// first; frame_end marks the thirteenth byte. The result channel moves one byte per
// transfer, and the byte serialiser sets the sustained command rate: it takes a new frame
// only as the last byte of the previous one leaves. A command passes three register
// stages (address and first CRC bytes, then two stages of four table-driven CRC bytes
// each) before the serialiser loads it into its shift register. The opcode register
// should only be written while no command is in flight.
module rs485_command_frame_builder (
   input  logic        clock,
   input  logic        reset,
   rcfb_req_if.sink    req_ch,
   rcfb_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   rcfb_pkg::byte_type  csr_opcode_ff;
   logic                s1_valid, s1_ready;
   rcfb_pkg::frame_type s1_data;
   logic                s2_valid, s2_ready;
   rcfb_pkg::frame_type s2_data;
   logic                s3_valid, s3_ready;
   rcfb_pkg::frame_type s3_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_opcode_ff <= '0;
      end else if (csr_wr_en) begin
         csr_opcode_ff <= csr_wr_data;
      end
   end

   rcfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .opcode    (csr_opcode_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   rcfb_crc_stage u_crc_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .blk       (s1_data.body[6:3]),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   rcfb_crc_stage u_crc_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .blk       (s2_data.body[10:7]),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   rcfb_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_valid),
      .in_ready (s3_ready),
      .in_data  (s3_data),
      .rsp      (rsp_ch)
   );

`ifndef SYNTHESIS
   // A frame never breaks off between bytes.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.frame_end) |=> rsp_ch.valid)
      else $error("result stream paused inside a frame");

   // The byte after a frame end, if present, opens a new frame.
   a_hdr_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.frame_end) ##1 rsp_ch.valid
      |-> (rsp_ch.tx_byte == rcfb_pkg::FrameHeader))
      else $error("frame following another does not start with the header");

   // Output starting from idle starts with the header.
   a_hdr_from_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !$past(rsp_ch.valid)) |-> (rsp_ch.tx_byte == rcfb_pkg::FrameHeader))
      else $error("frame from idle does not start with the header");
`endif

endmodule

[hdl/rcfb_front.sv]
module rcfb_front (
   input  logic                clock,
   input  logic                reset,
   rcfb_req_if.sink            req,
   input  rcfb_pkg::byte_type  opcode,
   output logic                out_valid,
   input  logic                out_ready,
   output rcfb_pkg::frame_type out_data
);

   logic                valid_ff, valid_in;
   rcfb_pkg::frame_type data_ff, data_in;
   rcfb_pkg::byte_type  addr;
   logic [15:0]         crc0, crc1;
   logic                take;

   assign req.ready = !valid_ff || out_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      addr = (req.broadcast || (req.command == opcode)) ? rcfb_pkg::BroadcastAddr
                                                        : req.motor_address;
      data_in.body[0] = rcfb_pkg::FrameHeader;
      data_in.body[1] = addr;
      data_in.body[2] = rcfb_pkg::LenField;
      data_in.body[3] = req.command;
      for (int i = 0; i < rcfb_pkg::PayloadBytes; i++) begin
         data_in.body[4+i] = req.payload[8*i +: 8];
      end
      // Header, address and length go into the CRC here.
      crc0         = rcfb_pkg::crc_byte(rcfb_pkg::CrcInit, rcfb_pkg::FrameHeader);
      crc1         = rcfb_pkg::crc_byte(crc0, addr);
      data_in.crc  = rcfb_pkg::crc_byte(crc1, rcfb_pkg::LenField);
      valid_in     = req.ready ? req.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hdl/rcfb_crc_stage.sv]
module rcfb_crc_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rcfb_pkg::frame_type in_data,
   input  rcfb_pkg::block_type blk,
   output logic                out_valid,
   input  logic                out_ready,
   output rcfb_pkg::frame_type out_data
);

   logic                valid_ff, valid_in;
   rcfb_pkg::frame_type data_ff, data_in;
   logic [15:0]         crc;

   assign in_ready = !valid_ff || out_ready;

   // Four dependent table steps; blk holds the bytes in transmission order.
   always_comb begin
      crc = in_data.crc;
      for (int i = 0; i < rcfb_pkg::BlockBytes; i++) begin
         crc = rcfb_pkg::crc_byte(crc, blk[i]);
      end
      data_in      = in_data;
      data_in.crc  = crc;
      valid_in     = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hdl/rcfb_serializer.sv]
module rcfb_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rcfb_pkg::frame_type in_data,
   rcfb_rsp_if.source          rsp
);

   logic                                           busy_ff, busy_in;
   logic [rcfb_pkg::CntWidth-1:0]                  cnt_ff, cnt_in;
   rcfb_pkg::byte_type [rcfb_pkg::FrameBytes-1:0]  sh_ff, sh_in;
   logic                                           last;
   logic                                           load;

   assign last     = (cnt_ff == rcfb_pkg::CntWidth'(rcfb_pkg::FrameBytes - 1));
   assign in_ready = !busy_ff || (rsp.ready && last);
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      if (busy_ff && rsp.ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
         for (int i = 0; i < rcfb_pkg::FrameBytes - 1; i++) begin
            sh_in[i] = sh_ff[i+1];
         end
      end
      // A new frame loads straight behind the last byte of the previous one.
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         for (int i = 0; i < rcfb_pkg::CrcSpan; i++) begin
            sh_in[i] = in_data.body[i];
         end
         sh_in[rcfb_pkg::CrcSpan]     = in_data.crc[7:0];
         sh_in[rcfb_pkg::CrcSpan + 1] = in_data.crc[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

   assign rsp.valid     = busy_ff;
   assign rsp.tx_byte   = sh_ff[0];
   assign rsp.frame_end = busy_ff && last;

endmodule

[bench/rs485_command_frame_builder_test.sv]
module rs485_command_frame_builder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 400_000;
   localparam int RandomPhases = 8;
   localparam int PhaseItems   = 56;
   localparam int DirectedRows = 16;

   typedef struct packed {
      rcfb_pkg::byte_type motor_address;
      logic               broadcast;
      rcfb_pkg::byte_type command;
      logic [55:0]        payload;
   } motor_command_type;

   // A row either programmes the opcode register or sends one command. Where the
   // address byte is obvious it is typed in; the rest of the frame is predicted.
   typedef struct packed {
      logic               set_opcode;
      rcfb_pkg::byte_type opcode;
      motor_command_type  cmd;
      logic               addr_typed;
      rcfb_pkg::byte_type want_addr;
   } directed_row_type;

   typedef rcfb_pkg::byte_type [rcfb_pkg::FrameBytes-1:0] bus_frame_type;

   typedef struct packed {
      rcfb_pkg::byte_type tx_byte;
      logic               frame_end;
   } wire_byte_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   rcfb_pkg::byte_type csr_wr_data;

   rcfb_req_if req_ch ();
   rcfb_rsp_if rsp_ch ();

   rs485_command_frame_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rcfb_pkg::byte_type opcode_shadow;
   wire_byte_type      pending_bytes[$];
   int                 sender_idle_pct;
   int                 receiver_stall_pct;
   int                 error_count;
   int                 cycle_count;
   int                 commands_sent;
   int                 broadcast_frames;
   int                 bytes_checked;

   directed_row_type directed_rows [DirectedRows] = '{
      '{1'b0, 8'h00, '{8'h12, 1'b0, 8'h00, 56'h0},                1'b1, 8'hCD},
      '{1'b0, 8'h00, '{8'h12, 1'b0, 8'h01, 56'h0},                1'b1, 8'h12},
      '{1'b0, 8'h00, '{8'h00, 1'b0, 8'hFF, 56'h0},                1'b1, 8'h00},
      '{1'b0, 8'h00, '{8'hFF, 1'b0, 8'h80, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 8'hFF},
      '{1'b0, 8'h00, '{8'hFF, 1'b1, 8'h01, 56'h0},                1'b1, 8'hCD},
      '{1'b0, 8'h00, '{8'h00, 1'b1, 8'h00, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 8'hCD},
      '{1'b0, 8'h00, '{8'h5A, 1'b0, 8'h42, 56'h07_0605_0403_0201}, 1'b0, 8'h00},
      '{1'b1, 8'hFF, '{8'h00, 1'b0, 8'h00, 56'h0},                1'b0, 8'h00},
      '{1'b0, 8'h00, '{8'h34, 1'b0, 8'hFF, 56'h0},                1'b1, 8'hCD},
      '{1'b0, 8'h00, '{8'h34, 1'b0, 8'h00, 56'h12_3456_789A_BCDE}, 1'b1, 8'h34},
      '{1'b0, 8'h00, '{8'h34, 1'b1, 8'hFF, 56'hFF_FFFF_FFFF_FFFF}, 1'b1, 8'hCD},
      '{1'b1, 8'h9C, '{8'h00, 1'b0, 8'h00, 56'h0},                1'b0, 8'h00},
      '{1'b0, 8'h00, '{8'hAB, 1'b0, 8'h9C, 56'h80_0000_0000_0001}, 1'b1, 8'hCD},
      '{1'b0, 8'h00, '{8'hAB, 1'b0, 8'h9D, 56'h01_0000_0000_0080}, 1'b1, 8'hAB},
      '{1'b0, 8'h00, '{8'hC3, 1'b0, 8'h11, 56'hAA_55AA_55AA_55AA}, 1'b0, 8'h00},
      '{1'b0, 8'h00, '{8'hCD, 1'b0, 8'h00, 56'h0},                1'b1, 8'hCD}
   };

   function automatic rcfb_pkg::byte_type address_byte(input motor_command_type c);
      return (c.broadcast || c.command == opcode_shadow) ? rcfb_pkg::BroadcastAddr
                                                         : c.motor_address;
   endfunction

   // Lays out the frame and appends the Modbus CRC, computed bit by bit.
   function automatic bus_frame_type build_frame(input rcfb_pkg::byte_type addr_byte,
                                                 input motor_command_type c);
      bus_frame_type f;
      logic [15:0]   crc;
      f[0] = rcfb_pkg::FrameHeader;
      f[1] = addr_byte;
      f[2] = rcfb_pkg::LenField;
      f[3] = c.command;
      for (int i = 0; i < rcfb_pkg::PayloadBytes; i++) begin
         f[4 + i] = c.payload[8*i +: 8];
      end
      crc = rcfb_pkg::CrcInit;
      for (int i = 0; i < rcfb_pkg::CrcSpan; i++) begin
         crc = crc ^ {8'h00, f[i]};
         for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ rcfb_pkg::CrcPoly) : (crc >> 1);
         end
      end
      f[11] = crc[7:0];
      f[12] = crc[15:8];
      return f;
   endfunction

   function automatic motor_command_type random_command();
      motor_command_type c;
      c.motor_address = ($urandom_range(9) == 0) ? rcfb_pkg::BroadcastAddr : 8'($urandom);
      c.broadcast     = ($urandom_range(3) == 0);
      c.command       = ($urandom_range(3) == 0) ? opcode_shadow : 8'($urandom);
      case ($urandom_range(9))
         0: begin
            c.payload = '0;
         end
         1: begin
            c.payload = '1;
         end
         default: begin
            c.payload = 56'({$urandom, $urandom});
         end
      endcase
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, with
   // valid left high so that a following command can go out without a gap.
   task automatic send_command(input motor_command_type c, input logic addr_typed,
                               input rcfb_pkg::byte_type want_addr);
      bus_frame_type      f;
      rcfb_pkg::byte_type addr;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.motor_address <= c.motor_address;
      req_ch.broadcast     <= c.broadcast;
      req_ch.command       <= c.command;
      req_ch.payload       <= c.payload;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      addr = addr_typed ? want_addr : address_byte(c);
      f = build_frame(addr, c);
      for (int i = 0; i < rcfb_pkg::FrameBytes; i++) begin
         pending_bytes.push_back('{f[i], (i == rcfb_pkg::FrameBytes - 1)});
      end
      commands_sent++;
      if (addr == rcfb_pkg::BroadcastAddr) begin
         broadcast_frames++;
      end
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic program_opcode(input rcfb_pkg::byte_type value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      opcode_shadow = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Run stopped after %0d cycles with %0d bytes outstanding",
                  cycle_count, pending_bytes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected transfer: tx_byte %h frame_end %b",
                   rsp_ch.tx_byte, rsp_ch.frame_end);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_ch.tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_ch.tx_byte);
               error_count++;
            end
            if (rsp_ch.frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_ch.frame_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.motor_address = '0;
      req_ch.broadcast     = 1'b0;
      req_ch.command       = '0;
      req_ch.payload       = '0;
      rsp_ch.ready         = 1'b0;
      opcode_shadow        = '0;
      sender_idle_pct      = 0;
      receiver_stall_pct   = 0;
      error_count          = 0;
      cycle_count          = 0;
      commands_sent        = 0;
      broadcast_frames     = 0;
      bytes_checked        = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_opcode) begin
            program_opcode(directed_rows[r].opcode);
         end else begin
            send_command(directed_rows[r].cmd, directed_rows[r].addr_typed,
                         directed_rows[r].want_addr);
         end
      end

      // Each phase reprogrammes the opcode and then runs under one idling pattern.
      for (int p = 0; p < RandomPhases; p++) begin
         case (p)
            0: program_opcode(8'hFF);
            1: program_opcode(8'h00);
            default: program_opcode(8'($urandom));
         endcase
         case (p % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 74;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 74;
            end
            default: begin
               sender_idle_pct    = 19;
               receiver_stall_pct = 19;
            end
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 2 && n == PhaseItems / 2) begin
               wait_for_drain();
            end
            send_command(random_command(), 1'b0, 8'h00);
         end
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait_for_drain();
      repeat (12) @(posedge clock);

      $display("%0d commands framed (%0d with the broadcast address), %0d bytes checked",
               commands_sent, broadcast_frames, bytes_checked);
      $display("Opcode register swept through its extremes and %0d random values",
               RandomPhases - 2);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
